// ===== rtl/core/bdpc_pkg.sv =====
// Shared types and constants for the button debounce / press classifier.
// Used by the interfaces, the config registers, the core and the top level.
`default_nettype none

package bdpc_pkg;

    localparam int unsigned NOW_W          = 32;   // width of the now_ms field
    localparam int unsigned CFG_W          = 16;   // width of every config register
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned TIME_WIDTH_DEF = 32;   // default width of time arithmetic (modulus 2^32)

    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST  = 16'd15;
    localparam logic [CFG_W-1:0] SHORT_MAX_MS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] HOLD_MS_RST      = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SHORT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD      = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] short_max_ms;
        logic [CFG_W-1:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic stable_level;
        logic press_event;
        logic release_event;
        logic short_press_event;
        logic hold_event;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdpc_if.sv =====
// Valid/ready channel interfaces for pin samples and classified results.
// Depends on bdpc_pkg for field widths.
`default_nettype none

interface bdpc_sample_if;
    import bdpc_pkg::*;

    logic             valid;
    logic             ready;
    logic             pin_level;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdpc_result_if;
    logic valid;
    logic ready;
    logic stable_level;
    logic press_event;
    logic release_event;
    logic short_press_event;
    logic hold_event;

    modport source (output valid, output stable_level, output press_event,
                    output release_event, output short_press_event,
                    output hold_event, input ready);
    modport sink   (input valid, input stable_level, input press_event,
                    input release_event, input short_press_event,
                    input hold_event, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/button_debounce_press_classifier.sv =====
// Top level of the button debounce and press classifier.
// Depends on bdpc_pkg, bdpc_if, bdpc_cfg_regs and bdpc_core.
`default_nettype none

// Each word on the samples channel is one poll of an active-low button
// (pin_level 0 = pressed) with a free-running millisecond time, and yields
// exactly one word on the results channel. A level that differs from the
// filter level restarts the debounce wait; once it has held for debounce_ms
// it becomes the stable level. A stable falling edge reports a press and arms
// the hold timer; a stable rising edge reports a release, plus a short press
// when still armed and the press lasted at most short_max_ms. An armed press
// held for hold_ms reports one hold event. Time differences wrap modulo
// 2^TIME_WIDTH. Throughput is one word per clock unless results.ready stalls
// the output. The sample lands in an input register, the whole state update
// runs as one combinational pass in bdpc_core, and the result is captured in
// an output register. That state update loop sets the rate. The input register
// accepts a new word whenever it is empty, or when its held sample advances
// because the result register is free or is drained in the same cycle. Write
// configuration through cfg_we/cfg_index/cfg_data only while the block is
// idle; writes to an index outside the three registers are dropped, the
// others take effect at the next clock edge.

module button_debounce_press_classifier #(
    parameter int unsigned TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bdpc_pkg::CFG_W-1:0]     cfg_data,
    bdpc_sample_if.sink                         samples,
    bdpc_result_if.source                       results
);
    import bdpc_pkg::*;

    cfg_t                  cfg;
    result_t               core_result;

    // input register stage
    logic                  in_valid_reg;
    logic                  in_pin_reg;
    logic [TIME_WIDTH-1:0] in_now_reg;
    logic [TIME_WIDTH-1:0] now_fit;

    // result register stage
    logic                  out_valid_reg;
    result_t               out_result_reg;

    logic                  step;
    logic                  in_take;

    // fit the 32-bit time field to the time modulus
    generate
        if (TIME_WIDTH > NOW_W)
        begin : g_now_ext
            assign now_fit = {{(TIME_WIDTH - NOW_W){1'b0}}, samples.now_ms};
        end
        else if (TIME_WIDTH == NOW_W)
        begin : g_now_same
            assign now_fit = samples.now_ms;
        end
        else
        begin : g_now_cut
            assign now_fit = samples.now_ms[TIME_WIDTH-1:0];
        end
    endgenerate

    // advance the held sample when the result register is free or draining
    assign step          = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || step;
    assign in_take       = samples.valid && samples.ready;

    bdpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdpc_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pin_level (in_pin_reg),
        .now_ms    (in_now_reg),
        .cfg       (cfg),
        .result    (core_result)
    );

    // input register: control resets, payload loads on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_pin_reg <= samples.pin_level;
            in_now_reg <= now_fit;
        end
    end

    // result register: load on step, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg <= core_result;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.stable_level      = out_result_reg.stable_level;
    assign results.press_event       = out_result_reg.press_event;
    assign results.release_event     = out_result_reg.release_event;
    assign results.short_press_event = out_result_reg.short_press_event;
    assign results.hold_event        = out_result_reg.hold_event;

    // a held sample stays held while the result side is blocked
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg)
        else $error("input sample lost while result register was blocked");

    // a short press only comes with the release that ends it
    a_short_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.short_press_event
        |-> out_result_reg.release_event && out_result_reg.stable_level)
        else $error("short press reported without a release");

    // a press leaves the stable level low and never pairs with a release
    a_press_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.press_event
        |-> !out_result_reg.stable_level && !out_result_reg.release_event)
        else $error("press event with inconsistent stable level");

    // a step always leaves a valid result behind
    a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result register empty after a step");

endmodule

`default_nettype wire

// ===== rtl/core/bdpc_cfg_regs.sv =====
// Configuration register file: debounce, short-press limit and hold time.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bdpc_pkg::CFG_W-1:0]     cfg_data,
    output bdpc_pkg::cfg_t                      cfg
);
    import bdpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_DEBOUNCE:  cfg_next.debounce_ms  = cfg_data;
                CFG_IDX_SHORT_MAX: cfg_next.short_max_ms = cfg_data;
                CFG_IDX_HOLD:      cfg_next.hold_ms      = cfg_data;
                default:           cfg_next = cfg_reg;   // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms  <= DEBOUNCE_MS_RST;
            cfg_reg.short_max_ms <= SHORT_MAX_MS_RST;
            cfg_reg.hold_ms      <= HOLD_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bdpc_core.sv =====
// Debounce and press classification state with its single-pass update logic.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_core #(
    parameter int unsigned TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  pin_level,
    input  wire logic [TIME_WIDTH-1:0] now_ms,
    input  wire bdpc_pkg::cfg_t        cfg,
    output bdpc_pkg::result_t          result
);
    import bdpc_pkg::*;

    logic                  filter_level_reg, filter_level_next;
    logic                  stable_reg, stable_next;
    logic                  settling_reg, settling_next;
    logic [TIME_WIDTH-1:0] settle_stamp_reg, settle_stamp_next;
    logic [TIME_WIDTH-1:0] press_stamp_reg, press_stamp_next;
    logic                  hold_armed_reg, hold_armed_next;

    logic                  level_change;
    logic                  settle_active;
    logic [TIME_WIDTH-1:0] settle_elapsed;
    logic                  settle_done;
    logic                  stable_edge;
    logic                  press_ev;
    logic                  release_ev;
    logic                  short_ev;
    logic                  hold_ev;
    logic [TIME_WIDTH-1:0] press_elapsed;
    logic [TIME_WIDTH-1:0] hold_elapsed;
    logic                  armed_mid;

    always_comb
    begin
        level_change   = (pin_level != filter_level_reg);
        settle_active  = settling_reg || level_change;
        // a fresh level restarts the wait, so its elapsed time is zero
        settle_elapsed = level_change ? '0 : (now_ms - settle_stamp_reg);
        settle_done    = settle_active
                         && (settle_elapsed >= TIME_WIDTH'(cfg.debounce_ms));
        stable_edge    = settle_done && (pin_level != stable_reg);
        press_ev       = stable_edge && !pin_level;
        release_ev     = stable_edge && pin_level;

        press_elapsed  = now_ms - press_stamp_reg;
        short_ev       = release_ev && hold_armed_reg
                         && (press_elapsed <= TIME_WIDTH'(cfg.short_max_ms));

        armed_mid      = press_ev ? 1'b1 : (release_ev ? 1'b0 : hold_armed_reg);
        hold_elapsed   = press_ev ? '0 : press_elapsed;
        hold_ev        = armed_mid && (hold_elapsed >= TIME_WIDTH'(cfg.hold_ms));

        filter_level_next = pin_level;
        settling_next     = settle_active && !settle_done;
        settle_stamp_next = level_change ? now_ms : settle_stamp_reg;
        stable_next       = stable_edge ? pin_level : stable_reg;
        press_stamp_next  = press_ev ? now_ms : press_stamp_reg;
        hold_armed_next   = armed_mid && !hold_ev;

        result.stable_level      = stable_next;
        result.press_event       = press_ev;
        result.release_event     = release_ev;
        result.short_press_event = short_ev;
        result.hold_event        = hold_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_level_reg <= 1'b1;
            stable_reg       <= 1'b1;
            settling_reg     <= 1'b0;
            settle_stamp_reg <= '0;
            press_stamp_reg  <= '0;
            hold_armed_reg   <= 1'b0;
        end
        else if (step)
        begin
            filter_level_reg <= filter_level_next;
            stable_reg       <= stable_next;
            settling_reg     <= settling_next;
            settle_stamp_reg <= settle_stamp_next;
            press_stamp_reg  <= press_stamp_next;
            hold_armed_reg   <= hold_armed_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/button_debounce_press_classifier_test.sv =====
// Self-checking bench for button_debounce_press_classifier: drives pin polls,
// predicts each result word in a local debounce/classifier model and checks it.
// Depends on bdpc_pkg and the bdpc_sample_if / bdpc_result_if interfaces.

module button_debounce_press_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdpc_pkg::*;

    // Pipe registers: input register, output register.
    localparam int unsigned PIPE_LAT    = 2;
    // Longest run of cycles with no word moving on either channel.
    localparam int unsigned STALL_LIMIT = 2000;
    // Percent of cycles each side sits idle when not in a steady stretch.
    localparam int unsigned IDLE_PCT    = 27;
    // Index 3 decodes to no register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    bdpc_sample_if sample_ch ();
    bdpc_result_if result_ch ();

    button_debounce_press_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    // Local copy of the register file, kept in step with every write.
    logic [CFG_W-1:0] debounce_cfg;
    logic [CFG_W-1:0] short_cfg;
    logic [CFG_W-1:0] hold_cfg;

    // Local copy of the debounce and press-timer state.
    logic             filter_q;
    logic             stable_q;
    logic             settling_q;
    logic             armed_q;
    logic [NOW_W-1:0] settle_at;
    logic [NOW_W-1:0] press_at;

    result_t          pending_results[$];
    int unsigned      mismatches   = 0;
    int unsigned      polls_sent   = 0;
    int unsigned      results_seen = 0;
    logic [NOW_W-1:0] clock_ms     = '0;
    // While set, neither side idles: the back-to-back stretch.
    bit               steady       = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic reset_model();
        debounce_cfg = DEBOUNCE_MS_RST;
        short_cfg    = SHORT_MAX_MS_RST;
        hold_cfg     = HOLD_MS_RST;
        filter_q     = 1'b1;
        stable_q     = 1'b1;
        settling_q   = 1'b0;
        armed_q      = 1'b0;   // timer starts disarmed: no hold after boot
        settle_at    = '0;
        press_at     = '0;
    endtask

    // Advance the local state by one poll and return the word it must produce.
    // Order within a poll: debounce filter, then stable edge, then hold check.
    // All time differences are taken modulo 2^32 by the 32-bit subtract.
    function automatic result_t classify_poll(input logic pin, input logic [NOW_W-1:0] now);
        result_t          r;
        logic [NOW_W-1:0] since_settle;
        logic [NOW_W-1:0] since_press;
        r = '0;
        // Restart the debounce wait on any change of the raw level.
        if (pin != filter_q)
        begin
            filter_q   = pin;
            settling_q = 1'b1;
            settle_at  = now;
        end
        since_settle = now - settle_at;
        if (settling_q && since_settle >= NOW_W'(debounce_cfg))
        begin
            settling_q = 1'b0;
            if (filter_q != stable_q)
            begin
                stable_q = filter_q;
                if (!stable_q)
                begin
                    // Falling edge: report press, stamp it, arm the hold timer.
                    r.press_event = 1'b1;
                    press_at      = now;
                    armed_q       = 1'b1;
                end
                else
                begin
                    // Rising edge: short press only if still armed and in time.
                    since_press = now - press_at;
                    if (armed_q && since_press <= NOW_W'(short_cfg))
                        r.short_press_event = 1'b1;
                    armed_q         = 1'b0;
                    r.release_event = 1'b1;
                end
            end
        end
        // Hold fires once, possibly in the same poll as the press.
        since_press = now - press_at;
        if (armed_q && since_press >= NOW_W'(hold_cfg))
        begin
            r.hold_event = 1'b1;
            armed_q      = 1'b0;
        end
        r.stable_level = stable_q;
        return r;
    endfunction

    // Predict on every accepted sample word, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
            pending_results.push_back(classify_poll(sample_ch.pin_level, sample_ch.now_ms));
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        // Cap the log; keep counting past the cap.
        if (mismatches < 100)
            $display("MISMATCH @%0t result word %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_bit(input string field, input logic want, input logic got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %b got %b", field, want, got));
    endtask

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin : check_word
        result_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result word with no poll waiting for it");
            else
            begin
                want = pending_results.pop_front();
                check_bit("stable_level", want.stable_level, result_ch.stable_level);
                check_bit("press_event", want.press_event, result_ch.press_event);
                check_bit("release_event", want.release_event, result_ch.release_event);
                check_bit("short_press_event", want.short_press_event,
                          result_ch.short_press_event);
                check_bit("hold_event", want.hold_event, result_ch.hold_event);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Result side: drop ready at random, hold it high in the steady stretch.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Send one poll word; idle first at random, then hold it until taken.
    task automatic send_poll(input logic pin, input logic [NOW_W-1:0] now);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge clk);
        sample_ch.valid     <= 1'b1;
        sample_ch.pin_level <= pin;
        sample_ch.now_ms    <= now;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        polls_sent++;
    endtask

    // Advance the free-running time by step and poll at the new time.
    task automatic advance_poll(input logic pin, input int unsigned step);
        clock_ms = clock_ms + step;
        send_poll(pin, clock_ms);
    endtask

    // Stop sending and wait until every predicted word has come back,
    // then let the pipe run dry before anything touches the registers.
    task automatic wait_drained();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_IDX_DEBOUNCE:  debounce_cfg = value;
            CFG_IDX_SHORT_MAX: short_cfg    = value;
            CFG_IDX_HOLD:      hold_cfg     = value;
            default: ;         // unmapped index: no register changes
        endcase
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] shrt,
                                input logic [CFG_W-1:0] hld);
        wait_drained();
        write_reg(CFG_IDX_DEBOUNCE, deb);
        write_reg(CFG_IDX_SHORT_MAX, shrt);
        write_reg(CFG_IDX_HOLD, hld);
    endtask

    // ------------------------------------------------------------------
    // Directed tests (reset register values unless noted)
    // ------------------------------------------------------------------

    // Released polls far apart after boot: the disarmed timer must stay quiet.
    task automatic test_boot_quiet();
        send_poll(1'b1, 32'd0);
        send_poll(1'b1, 32'd5000);
    endtask

    // Press, then release exactly at the short limit: short press counts.
    task automatic test_short_press_limit();
        send_poll(1'b0, 32'd10000);
        send_poll(1'b0, 32'd10015);   // debounce reached: press
        send_poll(1'b1, 32'd11000);
        send_poll(1'b1, 32'd11015);   // 1000 ms after the press: release + short
    endtask

    // Hold one ms short of the limit, then on it, then release: no short press.
    task automatic test_hold_then_release();
        send_poll(1'b0, 32'd20000);
        send_poll(1'b0, 32'd20015);
        send_poll(1'b0, 32'd23014);
        send_poll(1'b0, 32'd23015);   // hold fires once
        send_poll(1'b1, 32'd23100);
        send_poll(1'b1, 32'd23115);
    endtask

    // Bounce restarts the wait; the press lands a full debounce after the last edge.
    task automatic test_bounce_restart();
        send_poll(1'b0, 32'd30000);
        send_poll(1'b1, 32'd30005);
        send_poll(1'b0, 32'd30006);
        send_poll(1'b0, 32'd30020);   // 14 ms after the last edge: still settling
        send_poll(1'b0, 32'd30021);
        send_poll(1'b1, 32'd30100);
        send_poll(1'b1, 32'd30115);
    endtask

    // Debounce and press timing across the 32-bit time wrap.
    task automatic test_time_wrap();
        send_poll(1'b0, 32'hFFFF_FFF8);
        send_poll(1'b0, 32'h0000_0007);
        send_poll(1'b1, 32'h0000_0100);
        send_poll(1'b1, 32'h0000_010F);
    endtask

    // Register extremes and the unmapped register index.
    task automatic test_register_extremes();
        // Zero debounce and zero hold: press and hold in one poll.
        program_regs(16'd0, 16'd0, 16'd0);
        send_poll(1'b0, 32'd100);
        send_poll(1'b1, 32'd100);
        // Zero short limit still counts a short press for a release in the same ms.
        program_regs(16'd0, 16'd0, 16'd1);
        send_poll(1'b0, 32'd200);
        send_poll(1'b1, 32'd200);
        // Full-scale values; then a write to no register must change nothing.
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_IDX_UNUSED, 16'h0000);
        send_poll(1'b0, 32'd1000);
        send_poll(1'b0, 32'd66534);
        send_poll(1'b0, 32'd66535);
        send_poll(1'b0, 32'd132070);  // 65535 ms into the press: hold
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------

    // One press/release cycle with bounce, with poll spacing scaled to the
    // current registers so presses land on both sides of the short and hold limits.
    task automatic run_episode();
        logic        level;
        int unsigned span;
        level = 1'b0;
        repeat (2)
        begin
            if (!level)
                span = (32'(debounce_cfg)
                        + 32'(short_cfg > hold_cfg ? short_cfg : hold_cfg)) / 2 + 2;
            else
                span = 32'(debounce_cfg) + 2;
            repeat ($urandom_range(0, 3))
                advance_poll(1'($urandom_range(0, 1)), $urandom_range(0, 2));
            repeat ($urandom_range(1, 6))
                advance_poll(level, $urandom_range(0, span));
            level = ~level;
        end
    endtask

    // Mostly well-formed episodes; the rest is random level and time jumps.
    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] shrt,
                             input logic [CFG_W-1:0] hld, input int unsigned count,
                             input bit no_idle, input bit mid_drain);
        int unsigned goal;
        program_regs(deb, shrt, hld);
        steady = no_idle;
        goal   = polls_sent + count;
        while (polls_sent < goal)
        begin
            // Pause the sender once until every word has come back.
            if (mid_drain && polls_sent + count / 2 >= goal)
            begin
                wait_drained();
                mid_drain = 1'b0;
            end
            if ($urandom_range(0, 99) < 15)
            begin
                if ($urandom_range(0, 1))
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 50);
                send_poll(1'($urandom_range(0, 1)), clock_ms);
            end
            else
                run_episode();
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        clock_ms = 32'd200000;
        run_phase(DEBOUNCE_MS_RST, SHORT_MAX_MS_RST, HOLD_MS_RST, 380, 1'b0, 1'b0);
        run_phase(16'd3, 16'd20, 16'd50, 380, 1'b1, 1'b0);
        run_phase(16'd0, CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(1, 80)),
                  380, 1'b0, 1'b0);
        run_phase(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 150)),
                  CFG_W'($urandom_range(0, 300)), 380, 1'b0, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 380, 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Watchdog: end the run if no word moves on either channel for too long.
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Drive every block input to a known value from time zero.
        sample_ch.valid     = 1'b0;
        sample_ch.pin_level = 1'b1;
        sample_ch.now_ms    = '0;
        reset_model();
        // Hold reset, then release it away from the rising edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_boot_quiet();
        test_short_press_limit();
        test_hold_then_release();
        test_bounce_restart();
        test_time_wrap();
        test_register_extremes();
        test_random_traffic();

        // Drain every outstanding word, then let the pipe settle.
        wait_drained();
        repeat (PIPE_LAT + 4) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
